// ===== rtl/ddo_pkg.sv =====
// Shared types and constants for the differential-drive odometry block.
// Used by ddo_mul, ddo_cordic and differential_drive_odometry; no dependencies.
`default_nettype none

package ddo_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_SCALE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN   = 1'd1;

	localparam logic [31:0] WHEEL_SCALE_RST = 32'd74161;
	localparam logic [19:0] TURN_GAIN_RST   = 20'd161499;

	// ceil(2^60 / 15625): elapsed * this >> 34 gives the interval in seconds, Q.32
	localparam logic [63:0] DT_RECIP = 64'h0000_431B_DE82_D7B7;
	// 2^64 / 2pi, radians in Q.32 to a binary angle in bits 95..64
	localparam logic [63:0] INV_2PI  = 64'd2935890503282001219;

	// CORDIC datapath
	localparam int TRIG_W     = 34;
	localparam int ATAN_DEPTH = 32;
	localparam int ATAN_IDX_W = 5;
	localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 34'sd652032874;

	typedef struct packed {
		logic signed [15:0] left_speed;
		logic signed [15:0] right_speed;
		logic        [19:0] elapsed;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] x_pos;
		logic signed [31:0] y_pos;
		logic        [15:0] heading;
	} pose_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic        start;
		logic [31:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} cordic_rsp_t;

	// atan(2^-i) as a 32-bit binary angle
	function automatic logic [31:0] atan_angle(input logic [ATAN_IDX_W-1:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h2000_0000;
			5'd1:  r = 32'h12E4_051E;
			5'd2:  r = 32'h09FB_385B;
			5'd3:  r = 32'h0511_11D4;
			5'd4:  r = 32'h028B_0D43;
			5'd5:  r = 32'h0145_D7E1;
			5'd6:  r = 32'h00A2_F61E;
			5'd7:  r = 32'h0051_7C55;
			5'd8:  r = 32'h0028_BE53;
			5'd9:  r = 32'h0014_5F2F;
			5'd10: r = 32'h000A_2F98;
			5'd11: r = 32'h0005_17CC;
			5'd12: r = 32'h0002_8BE6;
			5'd13: r = 32'h0001_45F3;
			5'd14: r = 32'h0000_A2FA;
			5'd15: r = 32'h0000_517D;
			5'd16: r = 32'h0000_28BE;
			5'd17: r = 32'h0000_145F;
			5'd18: r = 32'h0000_0A30;
			5'd19: r = 32'h0000_0518;
			5'd20: r = 32'h0000_028C;
			5'd21: r = 32'h0000_0146;
			5'd22: r = 32'h0000_00A3;
			5'd23: r = 32'h0000_0051;
			5'd24: r = 32'h0000_0029;
			5'd25: r = 32'h0000_0014;
			5'd26: r = 32'h0000_000A;
			5'd27: r = 32'h0000_0005;
			5'd28: r = 32'h0000_0003;
			5'd29: r = 32'h0000_0001;
			5'd30: r = 32'h0000_0001;
			5'd31: r = 32'h0000_0000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/differential_drive_odometry.sv =====
// Top level of the differential-drive odometry block: sequencer, pose state, output register.
// Depends on ddo_pkg, ddo_mul and ddo_cordic.
`default_nettype none

// Dead-reckoning odometry. Each request carries signed left and right wheel speeds in
// encoder counts and the time since the previous sample in microseconds; the block moves
// its stored pose (x, y in Q16.32 metres, 32-bit binary heading) and returns one pose
// with x and y as Q16.16 and the top 16 bits of the heading. Position wraps modulo 2^48.
// Each request passes nine wide products, one at a time, through the single 32x32
// multiplier: seven to reach the heading, then the CORDIC rotation, then the x and y steps.
// sample_stall is high from acceptance until the pose is loaded into the output register;
// a finished pose sits in the output register so the next request can be taken while it waits.
// wheel_scale and turn_gain reset to 74161 and 161499 and must only be written while idle.
module differential_drive_odometry import ddo_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  sample_valid,
	output logic                       sample_stall,
	input  wire sample_t               sample,
	output logic                       pose_valid,
	input  wire logic                  pose_stall,
	output pose_t                      pose,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_ISSUE  = 6'b000010,
		S_MWAIT  = 6'b000100,
		S_CSTART = 6'b001000,
		S_CWAIT  = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	typedef enum logic [3:0] {
		OP_DT, OP_SW, OP_DIST, OP_DW, OP_RATE, OP_ANG, OP_BAM, OP_DX, OP_DY
	} mul_op_t;

	state_t  state_q;
	mul_op_t op_q;

	logic [31:0] wheel_scale_q;
	logic [19:0] turn_gain_q;
	logic [47:0] pos_x_q, pos_y_q;
	logic [31:0] heading_q;
	logic        pose_valid_q;

	// per-request working registers
	logic [19:0] el_q;
	logic [16:0] smag_q, dmag_q;
	logic        sneg_q, dneg_q;
	logic [32:0] dt_q;
	logic [52:0] wide_q;
	logic [48:0] dist_q;
	logic [31:0] mid_q;
	pose_t       pose_q;

	mul_req_t    mul_req;
	mul_rsp_t    mul_rsp;
	cordic_req_t cordic_req;
	cordic_rsp_t cordic_rsp;

	logic        take, pose_load;
	logic [16:0] sum, diff;
	logic [16:0] cos_mag, sin_mag;
	logic [TRIG_W-1:0] cos_abs, sin_abs;
	logic        negx, negy;
	logic [31:0] bam, turn, half;
	logic [47:0] dmove, step_x, step_y;

	assign take      = sample_valid && !sample_stall;
	assign pose_load = (state_q == S_EMIT) && (!pose_valid_q || !pose_stall);

	assign sum  = {sample.left_speed[15], sample.left_speed}
		+ {sample.right_speed[15], sample.right_speed};
	assign diff = {sample.right_speed[15], sample.right_speed}
		- {sample.left_speed[15], sample.left_speed};

	// trig magnitudes and the combined sign of each position step
	assign cos_abs = cordic_rsp.cos_v[TRIG_W-1] ? -cordic_rsp.cos_v : cordic_rsp.cos_v;
	assign sin_abs = cordic_rsp.sin_v[TRIG_W-1] ? -cordic_rsp.sin_v : cordic_rsp.sin_v;
	assign negx    = sneg_q ^ cordic_rsp.cos_v[TRIG_W-1];
	assign negy    = sneg_q ^ cordic_rsp.sin_v[TRIG_W-1];

	assign bam   = mul_rsp.prod[95:64];
	assign turn  = dneg_q ? (32'd0 - bam) : bam;
	assign half  = dneg_q ? (32'd0 - {1'b0, bam[31:1]}) : {1'b0, bam[31:1]};
	assign dmove = mul_rsp.prod[77:30];
	assign step_x = negx ? (48'd0 - dmove) : dmove;
	assign step_y = negy ? (48'd0 - dmove) : dmove;

	// unused high bits of the trig magnitudes are always zero
	assign cos_mag = 17'd0;
	assign sin_mag = 17'd0;

	always_comb begin
		mul_req.start = (state_q == S_ISSUE);
		mul_req.a     = '0;
		mul_req.b     = '0;
		unique case (op_q)
			OP_DT: begin
				mul_req.a = {44'd0, el_q};
				mul_req.b = DT_RECIP;
			end
			OP_SW: begin
				mul_req.a = {47'd0, smag_q};
				mul_req.b = {32'd0, wheel_scale_q};
			end
			OP_DIST: begin
				mul_req.a = {11'd0, wide_q};
				mul_req.b = {31'd0, dt_q};
			end
			OP_DW: begin
				mul_req.a = {47'd0, dmag_q};
				mul_req.b = {32'd0, wheel_scale_q};
			end
			OP_RATE: begin
				mul_req.a = {11'd0, wide_q};
				mul_req.b = {44'd0, turn_gain_q};
			end
			OP_ANG: begin
				mul_req.a = {11'd0, wide_q};
				mul_req.b = {31'd0, dt_q};
			end
			OP_BAM: begin
				mul_req.a = {11'd0, wide_q};
				mul_req.b = INV_2PI;
			end
			OP_DX: begin
				mul_req.a = {15'd0, dist_q};
				mul_req.b = {30'd0, cos_abs} | {47'd0, cos_mag};
			end
			OP_DY: begin
				mul_req.a = {15'd0, dist_q};
				mul_req.b = {30'd0, sin_abs} | {47'd0, sin_mag};
			end
			default: begin
				mul_req.a = '0;
				mul_req.b = '0;
			end
		endcase
	end

	assign cordic_req.start = (state_q == S_CSTART);
	assign cordic_req.angle = mid_q;

	ddo_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	ddo_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cordic_req),
		.rsp    (cordic_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= OP_DT;
			wheel_scale_q <= WHEEL_SCALE_RST;
			turn_gain_q   <= TURN_GAIN_RST;
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			heading_q     <= '0;
			pose_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WHEEL_SCALE: wheel_scale_q <= cfg_data;
					REG_TURN_GAIN:   turn_gain_q   <= cfg_data[19:0];
				endcase
			end

			if (pose_load)
				pose_valid_q <= 1'b1;
			else if (pose_valid_q && !pose_stall)
				pose_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						op_q    <= OP_DT;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (mul_rsp.done) begin
						unique case (op_q)
							OP_BAM: begin
								heading_q <= heading_q + turn;
								state_q   <= S_CSTART;
							end
							OP_DX: begin
								pos_x_q <= pos_x_q + step_x;
								op_q    <= OP_DY;
								state_q <= S_ISSUE;
							end
							OP_DY: begin
								pos_y_q <= pos_y_q + step_y;
								state_q <= S_EMIT;
							end
							default: begin
								op_q    <= mul_op_t'(op_q + 4'd1);
								state_q <= S_ISSUE;
							end
						endcase
					end
				end
				S_CSTART: state_q <= S_CWAIT;
				S_CWAIT: begin
					if (cordic_rsp.done) begin
						op_q    <= OP_DX;
						state_q <= S_ISSUE;
					end
				end
				S_EMIT: begin
					if (pose_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			el_q   <= sample.elapsed;
			sneg_q <= sum[16];
			dneg_q <= diff[16];
			smag_q <= sum[16] ? (17'd0 - sum) : sum;
			dmag_q <= diff[16] ? (17'd0 - diff) : diff;
		end
		if (state_q == S_MWAIT && mul_rsp.done) begin
			unique case (op_q)
				OP_DT:   dt_q   <= mul_rsp.prod[66:34];
				OP_SW:   wide_q <= mul_rsp.prod[52:0];
				OP_DIST: dist_q <= mul_rsp.prod[81:33];
				OP_DW:   wide_q <= mul_rsp.prod[52:0];
				OP_RATE: wide_q <= mul_rsp.prod[68:16];
				OP_ANG:  wide_q <= mul_rsp.prod[84:32];
				OP_BAM:  mid_q  <= heading_q + half;
				default: ;
			endcase
		end
		if (pose_load) begin
			pose_q.x_pos   <= signed'(pos_x_q[47:16]);
			pose_q.y_pos   <= signed'(pos_y_q[47:16]);
			pose_q.heading <= heading_q[31:16];
		end
	end

	assign sample_stall = (state_q != S_IDLE);
	assign pose_valid   = pose_valid_q;
	assign pose         = pose_q;

	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> state_q == S_MWAIT)
		else $error("multiplier finished outside its wait state");

	a_cordic_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_rsp.done |-> state_q == S_CWAIT)
		else $error("CORDIC finished outside its wait state");

	a_pose_drops_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(pose_valid && !pose_stall && !pose_load) |=> !pose_valid)
		else $error("pose stayed valid after it was taken with nothing new loaded");

endmodule

`default_nettype wire

// ===== rtl/ddo_mul.sv =====
// Shared 64x64 multiplier built from one 32x32 multiplier over four limb products.
// Depends on ddo_pkg (mul_req_t, mul_rsp_t).
`default_nettype none

module ddo_mul import ddo_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mul_req_t req,
	output mul_rsp_t      rsp
);

	logic [63:0]  a_q, b_q;
	logic [1:0]   cnt_q;
	logic         busy_q;
	logic [63:0]  prod_s1;
	logic [1:0]   sh_s1;
	logic         vld_s1, last_s1;
	logic [127:0] acc_q;
	logic         done_q;

	logic [31:0]  a_limb, b_limb;
	logic [127:0] addend;

	// cnt bit 0 picks the limb of a, bit 1 the limb of b
	assign a_limb = cnt_q[0] ? a_q[63:32] : a_q[31:0];
	assign b_limb = cnt_q[1] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		unique case (sh_s1)
			2'd0:    addend = {64'd0, prod_s1};
			2'd1:    addend = {32'd0, prod_s1, 32'd0};
			2'd2:    addend = {prod_s1, 64'd0};
			default: addend = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= busy_q;
			last_s1 <= busy_q && (cnt_q == 2'd3);
			done_q  <= vld_s1 && last_s1;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + addend;
		end
		prod_s1 <= 64'(a_limb) * 64'(b_limb);
		sh_s1   <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

`default_nettype wire

// ===== rtl/ddo_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on ddo_pkg (cordic_req_t, cordic_rsp_t, atan_angle).
`default_nettype none

module ddo_cordic import ddo_pkg::*; #(
	parameter int STEPS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cordic_req_t req,
	output cordic_rsp_t      rsp
);

	localparam int N = (STEPS > ATAN_DEPTH) ? ATAN_DEPTH : STEPS;
	localparam logic [ATAN_IDX_W-1:0] LAST = ATAN_IDX_W'(N - 1);

	logic                     busy_q, done_q, flip_q;
	logic [ATAN_IDX_W-1:0]    idx_q;
	logic signed [TRIG_W-1:0] x_q, y_q, z_q;

	logic                     flip;
	logic [31:0]              ang_in;
	logic signed [TRIG_W-1:0] xs, ys, step;

	// second and third quadrant: rotate by a half turn, negate at the end
	assign flip   = req.angle[31] ^ req.angle[30];
	assign ang_in = flip ? (req.angle ^ 32'h8000_0000) : req.angle;

	assign xs   = x_q >>> idx_q;
	assign ys   = y_q >>> idx_q;
	assign step = signed'({2'b00, atan_angle(idx_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			flip_q <= flip;
			x_q    <= CORDIC_X0;
			y_q    <= '0;
			z_q    <= signed'({{(TRIG_W-32){ang_in[31]}}, ang_in});
		end else if (busy_q) begin
			if (!z_q[TRIG_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - step;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + step;
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.cos_v = flip_q ? -x_q : x_q;
	assign rsp.sin_v = flip_q ? -y_q : y_q;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for differential_drive_odometry: drives wheel-speed requests, predicts each
// pose with an independent fixed-point model and compares it field by field.
// Depends on ddo_pkg and the RTL of the block only.

module tb;
	import ddo_pkg::*;

	localparam int STEPS   = 16;
	localparam int ROUNDS  = (STEPS > 32) ? 32 : STEPS;
	localparam int LIMIT   = 1_000_000;
	localparam int PER_SET = 290;

	localparam logic [63:0] TURNS_PER_RAD = 64'd2935890503282001219;
	localparam longint      GAIN_X0       = 652032874;
	localparam logic [0:31][31:0] ATAN_BAM = {
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
		32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
		32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
		32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
		32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
	};

	// one line of the directed plan: either a gain change or a sample request
	typedef struct packed {
		logic        cfg;
		logic [31:0] ws;
		logic [31:0] tg;
		sample_t     s;
		logic        typed;
		pose_t       want;
	} drow_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  sample_valid = 1'b0;
	sample_t               sample_in    = '0;
	logic                  pose_stall   = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  sample_stall;
	logic                  pose_valid;
	pose_t                 pose;

	// predicted register and pose state
	logic [31:0] wheel_scale_q = 32'd74161;
	logic [19:0] turn_gain_q   = 20'd161499;
	logic [47:0] pos_x         = '0;
	logic [47:0] pos_y         = '0;
	logic [31:0] head          = '0;

	pose_t pose_due[$];
	pose_t pose_want;
	drow_t plan[$];
	bit    idle_en    = 1'b1;
	int    mismatches = 0;
	int    poses_seen = 0;
	int    samples    = 0;
	int    settings   = 1;
	int    cycles     = 0;

	differential_drive_odometry #(.CORDIC_STEPS(STEPS)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample_in),
		.pose_valid   (pose_valid),
		.pose_stall   (pose_stall),
		.pose         (pose),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// low 64 bits of (a * b) >> sh
	function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
			input int sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> sh;
		return p[63:0];
	endfunction

	function automatic logic [47:0] step_axis(input logic [47:0] acc, input logic [63:0] dmag,
			input logic neg, input longint trig);
		logic [63:0] tm;
		logic [63:0] d;
		tm = 64'((trig < 0) ? -trig : trig);
		d  = mul_shift(dmag, tm, 30);
		if (neg ^ (trig < 0))
			d = -d;
		return acc + d[47:0];
	endfunction

	function automatic pose_t predict_pose(input sample_t s);
		int           sum_c;
		int           diff_c;
		logic [63:0]  smag;
		logic [63:0]  dmag;
		logic [63:0]  dt;
		logic [63:0]  travel;
		logic [63:0]  rate;
		logic [63:0]  ang;
		logic [127:0] wide;
		logic [31:0]  bam;
		logic [31:0]  turn;
		logic [31:0]  half;
		logic [31:0]  mid;
		logic [31:0]  za;
		logic         flip;
		longint       x;
		longint       y;
		longint       z;
		longint       xs;
		longint       ys;
		int           i;
		pose_t        p;
		sum_c  = int'(s.left_speed) + int'(s.right_speed);
		diff_c = int'(s.right_speed) - int'(s.left_speed);
		smag   = 64'((sum_c < 0) ? -sum_c : sum_c);
		dmag   = 64'((diff_c < 0) ? -diff_c : diff_c);
		dt     = ({44'd0, s.elapsed} << 26) / 64'd15625;
		travel = mul_shift(smag * {32'd0, wheel_scale_q}, dt, 33);
		rate   = mul_shift(dmag * {32'd0, wheel_scale_q}, {44'd0, turn_gain_q}, 16);
		ang    = mul_shift(rate, dt, 32);
		wide   = {64'd0, ang} * {64'd0, TURNS_PER_RAD};
		bam    = wide[95:64];
		turn   = (diff_c < 0) ? -bam : bam;
		half   = (diff_c < 0) ? -(bam >> 1) : (bam >> 1);
		mid    = head + half;
		head   = head + turn;
		// fold the midpoint into the right half-plane, negate afterwards
		flip = (mid[31:30] == 2'b01) || (mid[31:30] == 2'b10);
		za   = flip ? (mid ^ 32'h8000_0000) : mid;
		z    = longint'(signed'(za));
		x    = GAIN_X0;
		y    = 0;
		for (i = 0; i < ROUNDS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - longint'({32'd0, ATAN_BAM[i]});
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + longint'({32'd0, ATAN_BAM[i]});
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		pos_x = step_axis(pos_x, travel, sum_c < 0, x);
		pos_y = step_axis(pos_y, travel, sum_c < 0, y);
		p.x_pos   = pos_x[47:16];
		p.y_pos   = pos_y[47:16];
		p.heading = head[31:16];
		return p;
	endfunction

	function automatic drow_t row(input int l, input int r, input int e, input bit typed);
		drow_t d;
		d = '0;
		d.s.left_speed  = 16'(l);
		d.s.right_speed = 16'(r);
		d.s.elapsed     = 20'(e);
		d.typed         = typed;
		return d;
	endfunction

	function automatic drow_t gains(input logic [31:0] ws, input logic [31:0] tg);
		drow_t d;
		d = '0;
		d.cfg = 1'b1;
		d.ws  = ws;
		d.tg  = tg;
		return d;
	endfunction

	function automatic logic [15:0] extreme_speed();
		case ($urandom_range(4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'h0001;
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		int      kind;
		int      base;
		kind = $urandom_range(99);
		s.left_speed  = 16'($urandom);
		s.right_speed = 16'($urandom);
		s.elapsed     = 20'($urandom);
		if (kind >= 92) begin
			s.elapsed = 20'($urandom_range(1));
		end else if (kind >= 80) begin
			s.left_speed  = extreme_speed();
			s.right_speed = extreme_speed();
			case ($urandom_range(3))
				0: s.elapsed = 20'd0;
				1: s.elapsed = 20'd1;
				2: s.elapsed = 20'hFFFFF;
				default: s.elapsed = 20'h80000;
			endcase
		end else if (kind >= 45) begin
			// plausible driving: similar wheel speeds, millisecond-scale intervals
			base = int'($urandom_range(6000)) - 3000;
			s.left_speed  = 16'(base + int'($urandom_range(600)) - 300);
			s.right_speed = 16'(base + int'($urandom_range(600)) - 300);
			s.elapsed     = 20'($urandom_range(100000, 1000));
		end
		return s;
	endfunction

	task automatic send(input sample_t s, input bit typed, input pose_t want);
		pose_t calc;
		while (idle_en && $urandom_range(99) < 13) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_in    <= s;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		calc = predict_pose(s);
		pose_due.push_back(typed ? want : calc);
		samples++;
	endtask

	// valid is left high after a request so back-to-back requests need no gap
	task automatic drain();
		sample_valid <= 1'b0;
		while (pose_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_gains(input logic [31:0] ws, input logic [31:0] tg);
		cfg_we    <= 1'b1;
		cfg_index <= REG_WHEEL_SCALE;
		cfg_data  <= ws;
		@(posedge clk);
		cfg_index <= REG_TURN_GAIN;
		cfg_data  <= tg;
		@(posedge clk);
		cfg_we        <= 1'b0;
		wheel_scale_q = ws;
		turn_gain_q   = tg[19:0];
		settings++;
	endtask

	task automatic flag(input string name, input logic [31:0] want_v, input logic [31:0] got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("pose %0d, %s: expected %h, got %h", poses_seen, name, want_v, got_v);
	endtask

	always @(posedge clk) begin
		pose_stall <= idle_en && ($urandom_range(99) < 13);
		if (pose_valid && !pose_stall) begin
			poses_seen++;
			if (pose_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("pose %0d arrived with no request outstanding", poses_seen);
			end else begin
				pose_want = pose_due.pop_front();
				if (pose.x_pos !== pose_want.x_pos)
					flag("x_pos", pose_want.x_pos, pose.x_pos);
				if (pose.y_pos !== pose_want.y_pos)
					flag("y_pos", pose_want.y_pos, pose.y_pos);
				if (pose.heading !== pose_want.heading)
					flag("heading", {16'd0, pose_want.heading}, {16'd0, pose.heading});
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		int k;
		int p;
		int n;
		// from reset the pose is at the origin, so no-motion rows read as zero
		plan.push_back(row(0, 0, 0, 1'b1));
		plan.push_back(row(32767, -32768, 0, 1'b1));
		plan.push_back(row(-32768, 32767, 0, 1'b1));
		plan.push_back(row(-32768, -32768, 0, 1'b1));
		plan.push_back(row(0, 0, 20'hFFFFF, 1'b1));
		plan.push_back(row(32767, 32767, 20'hFFFFF, 1'b0));
		plan.push_back(row(-32768, -32768, 20'hFFFFF, 1'b0));
		plan.push_back(row(-1000, 1000, 20000, 1'b0));
		// turn almost half a revolution in one request, each way
		plan.push_back(row(32767, -32768, 20'hFFFFF, 1'b0));
		plan.push_back(row(-32768, 32767, 20'hFFFFF, 1'b0));
		plan.push_back(row(1, 0, 1, 1'b0));
		plan.push_back(row(0, -1, 1, 1'b0));
		plan.push_back(row(1500, 900, 20'hAAAAA, 1'b0));
		plan.push_back(row(-700, 2500, 20'h55555, 1'b0));
		// zero scale: nothing moves; turn gain upper bits must be dropped
		plan.push_back(gains(32'd0, 32'hFFFF_FFFF));
		plan.push_back(row(32767, -32768, 20'hFFFFF, 1'b0));
		plan.push_back(row(4000, 4000, 300000, 1'b0));
		// full scale, no turning: position wraps
		plan.push_back(gains(32'hFFFF_FFFF, 32'd0));
		plan.push_back(row(32767, 32767, 20'hFFFFF, 1'b0));
		plan.push_back(row(-32768, -32768, 20'hFFFFF, 1'b0));
		plan.push_back(row(20000, -3000, 700000, 1'b0));
		plan.push_back(gains(32'd1, 32'h000F_FFFF));
		plan.push_back(row(32767, -32768, 20'hFFFFF, 1'b0));
		plan.push_back(row(-12, 40, 999, 1'b0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < plan.size(); k++) begin
			if (plan[k].cfg) begin
				drain();
				load_gains(plan[k].ws, plan[k].tg);
			end else begin
				send(plan[k].s, plan[k].typed, plan[k].want);
			end
		end

		for (p = 0; p < 5; p++) begin
			drain();
			idle_en = (p != 1);
			case (p)
				0: load_gains(32'($urandom_range(400000, 20000)), 32'($urandom_range(20'hFFFFF)));
				1: load_gains($urandom, $urandom);
				2: load_gains(32'hFFFF_FFFF, 32'h000F_FFFF);
				3: load_gains(32'd1, 32'd0);
				default: load_gains(32'd74161, 32'd161499);
			endcase
			for (n = 0; n < PER_SET; n++)
				send(rand_sample(), 1'b0, '0);
		end

		drain();
		repeat (200) @(posedge clk);
		$display("run: %0d samples over %0d gain settings, %0d poses compared, %0d mismatches",
			samples, settings, poses_seen, mismatches);
		if (mismatches == 0 && pose_due.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
